### rtl/obl3_pkg.sv
// Shared constants, beat types and dedup handshake types for the L3 order book.
package obl3_pkg;

    localparam int ORDER_SLOTS     = 1024;
    localparam int LEVELS_PER_SIDE = 256;
    localparam int SEEN_SLOTS      = 1024;

    localparam int NLVL  = 2 * LEVELS_PER_SIDE;
    localparam int OAW   = $clog2(ORDER_SLOTS);
    localparam int LAW   = $clog2(NLVL);
    localparam int SAW   = $clog2(SEEN_SLOTS);
    localparam int CLR_N = (ORDER_SLOTS > NLVL) ? ORDER_SLOTS : NLVL;
    localparam int CW    = $clog2(CLR_N);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TRADE  = 2'd2,
        CMD_OTHER  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic               buy_sell;
        logic [39:0]        order_ref;
        logic [31:0]        limit_price;
        logic signed [31:0] volume;
        logic [47:0]        event_time;
        logic [31:0]        sequence_no;
        logic [39:0]        exec_ref;
    } in_item_t;

    typedef struct packed {
        logic        exec_valid;
        logic [39:0] exec_ref_out;
        logic [31:0] exec_price;
        logic [30:0] exec_volume;
        logic [47:0] exec_time;
        logic [31:0] exec_sequence;
        logic        bid_present;
        logic [31:0] best_bid_price;
        logic [47:0] best_bid_volume;
        logic        ask_present;
        logic [31:0] best_ask_price;
        logic [47:0] best_ask_volume;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [39:0] xref;
    } dd_req_t;

    typedef struct packed {
        logic busy;
        logic fresh;
    } dd_rsp_t;

endpackage

### rtl/obl3_dedup.sv
// Execution reference dedup ring: walk filled entries, record first-seen refs.
module obl3_dedup (
    input  logic              aclk,
    input  logic              aresetn,
    input  obl3_pkg::dd_req_t req,
    output obl3_pkg::dd_rsp_t rsp
);
    import obl3_pkg::*;

    logic [39:0]    seen_mem [SEEN_SLOTS];
    logic [39:0]    rd_reg;
    logic [39:0]    xref_reg, xref_next;
    logic           busy_reg, busy_next;
    logic           issue_reg, issue_next;
    logic           rv_reg, rv_next;
    logic           rl_reg, rl_next;
    logic           found_reg, found_next;
    logic           fresh_reg, fresh_next;
    logic [SAW-1:0] addr_reg, addr_next;
    logic [SAW-1:0] wp_reg, wp_next;
    logic [SAW:0]   fill_reg, fill_next;
    logic           rd_en, we, hit_now, last_issue;

    always_comb begin
        xref_next  = xref_reg;
        busy_next  = busy_reg;
        issue_next = issue_reg;
        rv_next    = rv_reg;
        rl_next    = rl_reg;
        found_next = found_reg;
        fresh_next = fresh_reg;
        addr_next  = addr_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        rd_en      = 1'b0;
        we         = 1'b0;
        hit_now    = rv_reg && (rd_reg == xref_reg);
        last_issue = ({1'b0, addr_reg} == (fill_reg - 1'b1));
        if (req.start) begin
            busy_next  = 1'b1;
            xref_next  = req.xref;
            issue_next = (fill_reg != '0);
            addr_next  = '0;
            found_next = 1'b0;
            rv_next    = 1'b0;
        end else if (busy_reg) begin
            rv_next = issue_reg;
            rl_next = last_issue;
            if (issue_reg) begin
                rd_en = 1'b1;
                if (last_issue) begin
                    issue_next = 1'b0;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            if (hit_now) begin
                found_next = 1'b1;
            end
            // finish after the last filled entry, or at once on an empty ring
            if ((rv_reg && rl_reg) || (!issue_reg && !rv_reg)) begin
                busy_next  = 1'b0;
                fresh_next = !(found_reg || hit_now);
                if (!(found_reg || hit_now)) begin
                    we      = 1'b1;
                    wp_next = (wp_reg == SAW'(SEEN_SLOTS - 1)) ? '0 : wp_reg + 1'b1;
                    if (fill_reg != (SAW + 1)'(SEEN_SLOTS)) begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_reg <= seen_mem[addr_reg];
        end
        if (we) begin
            seen_mem[wp_reg] <= xref_reg;
        end
    end

    always_ff @(posedge aclk) begin
        xref_reg <= xref_next;
        addr_reg <= addr_next;
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            issue_reg <= 1'b0;
            rv_reg    <= 1'b0;
            rl_reg    <= 1'b0;
            found_reg <= 1'b0;
            fresh_reg <= 1'b0;
            wp_reg    <= '0;
            fill_reg  <= '0;
        end else begin
            busy_reg  <= busy_next;
            issue_reg <= issue_next;
            rv_reg    <= rv_next;
            rl_reg    <= rl_next;
            found_reg <= found_next;
            fresh_reg <= fresh_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
        end
    end

    assign rsp.busy  = busy_reg;
    assign rsp.fresh = fresh_reg;

endmodule

### rtl/order_book_l3_update.sv
// Top level of the per-order (L3) limit order book update engine.
// Per-order book engine: one input beat (add, cancel, trade or ignored event)
// produces one result beat carrying an optional execution record and the best
// bid and best ask with their summed volume. Orders live in a 1024-entry
// single-port-read memory, price levels in a 512-entry memory (lower half bids,
// upper half ask), and execution references in a 1024-entry dedup ring inside
// obl3_dedup. After reset the block runs a clearing pass over the larger of
// the order and level stores with s_ready low. Each event is handled by
// walking memories one entry per cycle with a registered read: an accepted
// add, a cancel or a positive-volume trade walks all order slots, then up to
// two walks over one side's levels, or a level wipe of one side for a
// whole-side cancel; every event ends with a walk over all levels to find the
// best prices. The dedup walk runs beside the order work and over at most
// 1024 filled entries. The input is taken whenever the engine is idle, even
// while the previous result beat still waits in the output register.
module order_book_l3_update (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  obl3_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output obl3_pkg::out_item_t m_data
);
    import obl3_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR   = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_OSCAN   = 9'b000000100,
        ST_ODECIDE = 9'b000001000,
        ST_LWIPE   = 9'b000010000,
        ST_LSCAN   = 9'b000100000,
        ST_LDECIDE = 9'b001000000,
        ST_BEST    = 9'b010000000,
        ST_OUT     = 9'b100000000
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE        = 3'd0,
        OP_ADD         = 3'd1,
        OP_CANCEL_ONE  = 3'd2,
        OP_CANCEL_SIDE = 3'd3,
        OP_REDUCE      = 3'd4
    } op_t;

    typedef struct packed {
        logic        valid;
        logic [39:0] order_ref;
        logic        side;
        logic [31:0] price;
        logic [30:0] vol;
    } order_ent_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] price;
        logic [47:0] vol;
    } level_ent_t;

    function automatic logic [LAW-1:0] side_base(input logic side);
        return side ? LAW'(LEVELS_PER_SIDE) : '0;
    endfunction

    // storage
    order_ent_t order_mem [ORDER_SLOTS];
    level_ent_t level_mem [NLVL];

    state_t         state_reg, state_next;
    in_item_t       item_reg, item_next;
    op_t            op_reg, op_next;
    logic [30:0]    q_reg, q_next;
    logic           xchk_reg, xchk_next;
    logic [CW-1:0]  clr_reg, clr_next;

    // order walk
    logic [OAW-1:0] o_addr_reg, o_addr_next;
    logic           o_issue_reg, o_issue_next;
    logic           o_rv_reg, o_rv_next;
    logic           o_rl_reg, o_rl_next;
    logic [OAW-1:0] o_ri_reg, o_ri_next;
    order_ent_t     o_rd_reg;
    logic           hit_reg, hit_next;
    logic [OAW-1:0] hit_idx_reg, hit_idx_next;
    order_ent_t     hit_ent_reg, hit_ent_next;
    logic           free_reg, free_next;
    logic [OAW-1:0] free_idx_reg, free_idx_next;
    logic [OAW-1:0] slot_reg, slot_next;

    // level walk
    logic [LAW-1:0] l_addr_reg, l_addr_next;
    logic [LAW-1:0] l_end_reg, l_end_next;
    logic           l_issue_reg, l_issue_next;
    logic           l_rv_reg, l_rv_next;
    logic           l_rl_reg, l_rl_next;
    logic [LAW-1:0] l_ri_reg, l_ri_next;
    level_ent_t     l_rd_reg;
    logic           l_add_reg, l_add_next;
    logic           l_side_reg, l_side_next;
    logic [31:0]    l_price_reg, l_price_next;
    logic [30:0]    l_amt_reg, l_amt_next;
    logic           lhit_reg, lhit_next;
    logic [LAW-1:0] lhit_idx_reg, lhit_idx_next;
    logic [47:0]    lhit_vol_reg, lhit_vol_next;
    logic           lfree_reg, lfree_next;
    logic [LAW-1:0] lfree_idx_reg, lfree_idx_next;

    // best-level search
    logic           bid_have_reg, bid_have_next;
    logic [31:0]    bid_price_reg, bid_price_next;
    logic [47:0]    bid_vol_reg, bid_vol_next;
    logic           ask_have_reg, ask_have_next;
    logic [31:0]    ask_price_reg, ask_price_next;
    logic [47:0]    ask_vol_reg, ask_vol_next;

    logic [31:0]    seq_cnt_reg, seq_cnt_next;
    logic           m_valid_reg, m_valid_next;
    out_item_t      m_data_reg, m_data_next;

    // memory ports
    logic           o_we, o_ren, l_we, l_ren;
    logic [OAW-1:0] o_wa;
    order_ent_t     o_wd;
    logic [LAW-1:0] l_wa;
    level_ent_t     l_wd;

    dd_req_t        dd_req;
    dd_rsp_t        dd_rsp;

    logic           s_pos, go_best, start_l, fire;
    op_t            op_sel;
    logic [47:0]    amt48, sub_vol;
    logic [48:0]    sum49;
    logic [47:0]    add_vol;
    order_ent_t     new_ord;

    obl3_dedup u_dedup (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dd_req),
        .rsp     (dd_rsp)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        op_next        = op_reg;
        q_next         = q_reg;
        xchk_next      = xchk_reg;
        clr_next       = clr_reg;
        o_addr_next    = o_addr_reg;
        o_issue_next   = o_issue_reg;
        o_rv_next      = o_rv_reg;
        o_rl_next      = o_rl_reg;
        o_ri_next      = o_ri_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_ent_next   = hit_ent_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        slot_next      = slot_reg;
        l_addr_next    = l_addr_reg;
        l_end_next     = l_end_reg;
        l_issue_next   = l_issue_reg;
        l_rv_next      = l_rv_reg;
        l_rl_next      = l_rl_reg;
        l_ri_next      = l_ri_reg;
        l_add_next     = l_add_reg;
        l_side_next    = l_side_reg;
        l_price_next   = l_price_reg;
        l_amt_next     = l_amt_reg;
        lhit_next      = lhit_reg;
        lhit_idx_next  = lhit_idx_reg;
        lhit_vol_next  = lhit_vol_reg;
        lfree_next     = lfree_reg;
        lfree_idx_next = lfree_idx_reg;
        bid_have_next  = bid_have_reg;
        bid_price_next = bid_price_reg;
        bid_vol_next   = bid_vol_reg;
        ask_have_next  = ask_have_reg;
        ask_price_next = ask_price_reg;
        ask_vol_next   = ask_vol_reg;
        seq_cnt_next   = seq_cnt_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        o_we    = 1'b0;
        o_ren   = 1'b0;
        o_wa    = o_ri_reg;
        o_wd    = '0;
        l_we    = 1'b0;
        l_ren   = 1'b0;
        l_wa    = l_ri_reg;
        l_wd    = '0;
        dd_req  = '0;
        go_best = 1'b0;
        start_l = 1'b0;
        fire    = 1'b0;
        op_sel  = OP_NONE;

        s_pos   = (s_data.volume > 32'sd0);
        amt48   = 48'(l_amt_reg);
        sub_vol = (amt48 >= lhit_vol_reg) ? '0 : lhit_vol_reg - amt48;
        sum49   = {1'b0, lhit_vol_reg} + 49'(l_amt_reg);
        add_vol = sum49[48] ? '1 : sum49[47:0];

        new_ord.valid     = 1'b1;
        new_ord.order_ref = item_reg.order_ref;
        new_ord.side      = item_reg.buy_sell;
        new_ord.price     = item_reg.limit_price;
        new_ord.vol       = q_reg;

        // drain the output register
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // shared level read walk for the side walk and the best search
        if ((state_reg == ST_LSCAN) || (state_reg == ST_BEST)) begin
            l_rv_next = l_issue_reg;
            if (l_issue_reg) begin
                l_ren     = 1'b1;
                l_ri_next = l_addr_reg;
                l_rl_next = (l_addr_reg == l_end_reg);
                if (l_addr_reg == l_end_reg) begin
                    l_issue_next = 1'b0;
                end else begin
                    l_addr_next = l_addr_reg + 1'b1;
                end
            end
        end

        unique case (state_reg)
            ST_CLEAR: begin
                if ({1'b0, clr_reg} < (CW + 1)'(ORDER_SLOTS)) begin
                    o_we = 1'b1;
                    o_wa = clr_reg[OAW-1:0];
                end
                if ({1'b0, clr_reg} < (CW + 1)'(NLVL)) begin
                    l_we = 1'b1;
                    l_wa = clr_reg[LAW-1:0];
                end
                if (clr_reg == CW'(CLR_N - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            ST_IDLE: begin
                if (s_valid) begin
                    item_next     = s_data;
                    q_next        = s_pos ? s_data.volume[30:0] : '0;
                    xchk_next     = 1'b0;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    unique case (s_data.cmd)
                        CMD_ADD: begin
                            op_sel = (s_pos && (s_data.limit_price != '0)) ? OP_ADD : OP_NONE;
                        end
                        CMD_CANCEL: begin
                            op_sel = (s_data.order_ref == '0) ? OP_CANCEL_SIDE : OP_CANCEL_ONE;
                        end
                        CMD_TRADE: begin
                            op_sel = s_pos ? OP_REDUCE : OP_NONE;
                            if (s_data.exec_ref != '0) begin
                                dd_req.start = 1'b1;
                                dd_req.xref  = s_data.exec_ref;
                                xchk_next    = 1'b1;
                            end
                        end
                        default: begin
                            op_sel = OP_NONE;
                        end
                    endcase
                    op_next = op_sel;
                    if (op_sel == OP_NONE) begin
                        go_best = 1'b1;
                    end else begin
                        state_next   = ST_OSCAN;
                        o_addr_next  = '0;
                        o_issue_next = 1'b1;
                        o_rv_next    = 1'b0;
                    end
                end
            end

            ST_OSCAN: begin
                o_rv_next = o_issue_reg;
                if (o_issue_reg) begin
                    o_ren     = 1'b1;
                    o_ri_next = o_addr_reg;
                    o_rl_next = (o_addr_reg == OAW'(ORDER_SLOTS - 1));
                    if (o_addr_reg == OAW'(ORDER_SLOTS - 1)) begin
                        o_issue_next = 1'b0;
                    end else begin
                        o_addr_next = o_addr_reg + 1'b1;
                    end
                end
                if (o_rv_reg) begin
                    if (o_rd_reg.valid && (o_rd_reg.order_ref == item_reg.order_ref)
                        && !hit_reg) begin
                        hit_next     = 1'b1;
                        hit_idx_next = o_ri_reg;
                        hit_ent_next = o_rd_reg;
                    end
                    if (!o_rd_reg.valid && !free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = o_ri_reg;
                    end
                    // whole-side cancel: drop every resting order of that side
                    if ((op_reg == OP_CANCEL_SIDE) && o_rd_reg.valid
                        && (o_rd_reg.side == item_reg.buy_sell)) begin
                        o_we = 1'b1;
                    end
                    if (o_rl_reg) begin
                        state_next = ST_ODECIDE;
                    end
                end
            end

            ST_ODECIDE: begin
                l_side_next  = hit_ent_reg.side;
                l_price_next = hit_ent_reg.price;
                l_amt_next   = hit_ent_reg.vol;
                l_add_next   = 1'b0;
                unique case (op_reg)
                    OP_CANCEL_SIDE: begin
                        l_addr_next = side_base(item_reg.buy_sell);
                        l_end_next  = side_base(item_reg.buy_sell)
                                      + LAW'(LEVELS_PER_SIDE - 1);
                        state_next  = ST_LWIPE;
                    end
                    OP_CANCEL_ONE: begin
                        if (hit_reg) begin
                            o_we    = 1'b1;
                            o_wa    = hit_idx_reg;
                            start_l = 1'b1;
                        end else begin
                            go_best = 1'b1;
                        end
                    end
                    OP_REDUCE: begin
                        if (hit_reg) begin
                            o_we    = 1'b1;
                            o_wa    = hit_idx_reg;
                            start_l = 1'b1;
                            if (q_reg < hit_ent_reg.vol) begin
                                o_wd       = hit_ent_reg;
                                o_wd.vol   = hit_ent_reg.vol - q_reg;
                                l_amt_next = q_reg;
                            end
                        end else begin
                            go_best = 1'b1;
                        end
                    end
                    OP_ADD: begin
                        if (hit_reg) begin
                            // replace: remove the old order first
                            o_we      = 1'b1;
                            o_wa      = hit_idx_reg;
                            slot_next = free_reg ? free_idx_reg : hit_idx_reg;
                            start_l   = 1'b1;
                        end else if (free_reg) begin
                            slot_next    = free_idx_reg;
                            l_side_next  = item_reg.buy_sell;
                            l_price_next = item_reg.limit_price;
                            l_amt_next   = q_reg;
                            l_add_next   = 1'b1;
                            start_l      = 1'b1;
                        end else begin
                            go_best = 1'b1;
                        end
                    end
                    default: begin
                        go_best = 1'b1;
                    end
                endcase
            end

            ST_LWIPE: begin
                l_we = 1'b1;
                l_wa = l_addr_reg;
                if (l_addr_reg == l_end_reg) begin
                    go_best = 1'b1;
                end else begin
                    l_addr_next = l_addr_reg + 1'b1;
                end
            end

            ST_LSCAN: begin
                if (l_rv_reg) begin
                    if (l_rd_reg.valid && (l_rd_reg.price == l_price_reg) && !lhit_reg) begin
                        lhit_next     = 1'b1;
                        lhit_idx_next = l_ri_reg;
                        lhit_vol_next = l_rd_reg.vol;
                    end
                    if (!l_rd_reg.valid && !lfree_reg) begin
                        lfree_next     = 1'b1;
                        lfree_idx_next = l_ri_reg;
                    end
                    if (l_rl_reg) begin
                        state_next = ST_LDECIDE;
                    end
                end
            end

            ST_LDECIDE: begin
                if (!l_add_reg) begin
                    if (lhit_reg) begin
                        l_we       = 1'b1;
                        l_wa       = lhit_idx_reg;
                        l_wd.valid = (sub_vol != '0);
                        l_wd.price = l_price_reg;
                        l_wd.vol   = sub_vol;
                    end
                    if (op_reg == OP_ADD) begin
                        l_side_next  = item_reg.buy_sell;
                        l_price_next = item_reg.limit_price;
                        l_amt_next   = q_reg;
                        l_add_next   = 1'b1;
                        start_l      = 1'b1;
                    end else begin
                        go_best = 1'b1;
                    end
                end else begin
                    if (lhit_reg) begin
                        l_we       = 1'b1;
                        l_wa       = lhit_idx_reg;
                        l_wd.valid = 1'b1;
                        l_wd.price = l_price_reg;
                        l_wd.vol   = add_vol;
                        o_we       = 1'b1;
                        o_wa       = slot_reg;
                        o_wd       = new_ord;
                    end else if (lfree_reg) begin
                        l_we       = 1'b1;
                        l_wa       = lfree_idx_reg;
                        l_wd.valid = 1'b1;
                        l_wd.price = l_price_reg;
                        l_wd.vol   = amt48;
                        o_we       = 1'b1;
                        o_wa       = slot_reg;
                        o_wd       = new_ord;
                    end
                    go_best = 1'b1;
                end
            end

            ST_BEST: begin
                if (l_rv_reg && l_rd_reg.valid) begin
                    if (l_ri_reg < LAW'(LEVELS_PER_SIDE)) begin
                        if (!bid_have_reg || (l_rd_reg.price > bid_price_reg)) begin
                            bid_have_next  = 1'b1;
                            bid_price_next = l_rd_reg.price;
                            bid_vol_next   = l_rd_reg.vol;
                        end
                    end else begin
                        if (!ask_have_reg || (l_rd_reg.price < ask_price_reg)) begin
                            ask_have_next  = 1'b1;
                            ask_price_next = l_rd_reg.price;
                            ask_vol_next   = l_rd_reg.vol;
                        end
                    end
                end
                if (l_rv_reg && l_rl_reg) begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT: begin
                // hold until the dedup walk is done and the output register is free
                if (!dd_rsp.busy && (!m_valid_reg || m_ready)) begin
                    fire = xchk_reg && dd_rsp.fresh;
                    m_data_next = '0;
                    if (fire) begin
                        m_data_next.exec_valid   = 1'b1;
                        m_data_next.exec_ref_out = item_reg.exec_ref;
                        m_data_next.exec_price   = item_reg.limit_price;
                        m_data_next.exec_volume  = q_reg;
                        m_data_next.exec_time    = item_reg.event_time;
                        if (item_reg.sequence_no != '0) begin
                            m_data_next.exec_sequence = item_reg.sequence_no;
                        end else begin
                            m_data_next.exec_sequence = seq_cnt_reg;
                            seq_cnt_next              = seq_cnt_reg + 1'b1;
                        end
                    end
                    if (bid_have_reg) begin
                        m_data_next.bid_present     = 1'b1;
                        m_data_next.best_bid_price  = bid_price_reg;
                        m_data_next.best_bid_volume = bid_vol_reg;
                    end
                    if (ask_have_reg) begin
                        m_data_next.ask_present     = 1'b1;
                        m_data_next.best_ask_price  = ask_price_reg;
                        m_data_next.best_ask_volume = ask_vol_reg;
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // launch a walk over one side's levels
        if (start_l) begin
            state_next   = ST_LSCAN;
            l_addr_next  = side_base(l_side_next);
            l_end_next   = side_base(l_side_next) + LAW'(LEVELS_PER_SIDE - 1);
            l_issue_next = 1'b1;
            l_rv_next    = 1'b0;
            lhit_next    = 1'b0;
            lfree_next   = 1'b0;
        end

        // launch the best-price walk over both sides
        if (go_best) begin
            state_next    = ST_BEST;
            l_addr_next   = '0;
            l_end_next    = LAW'(NLVL - 1);
            l_issue_next  = 1'b1;
            l_rv_next     = 1'b0;
            bid_have_next = 1'b0;
            ask_have_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_we) begin
            order_mem[o_wa] <= o_wd;
        end
        if (o_ren) begin
            o_rd_reg <= order_mem[o_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (l_we) begin
            level_mem[l_wa] <= l_wd;
        end
        if (l_ren) begin
            l_rd_reg <= level_mem[l_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        op_reg         <= op_next;
        q_reg          <= q_next;
        o_addr_reg     <= o_addr_next;
        o_ri_reg       <= o_ri_next;
        hit_idx_reg    <= hit_idx_next;
        hit_ent_reg    <= hit_ent_next;
        free_idx_reg   <= free_idx_next;
        slot_reg       <= slot_next;
        l_addr_reg     <= l_addr_next;
        l_end_reg      <= l_end_next;
        l_ri_reg       <= l_ri_next;
        l_side_reg     <= l_side_next;
        l_price_reg    <= l_price_next;
        l_amt_reg      <= l_amt_next;
        lhit_idx_reg   <= lhit_idx_next;
        lhit_vol_reg   <= lhit_vol_next;
        lfree_idx_reg  <= lfree_idx_next;
        bid_price_reg  <= bid_price_next;
        bid_vol_reg    <= bid_vol_next;
        ask_price_reg  <= ask_price_next;
        ask_vol_reg    <= ask_vol_next;
        m_data_reg     <= m_data_next;
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            xchk_reg     <= 1'b0;
            o_issue_reg  <= 1'b0;
            o_rv_reg     <= 1'b0;
            o_rl_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            l_issue_reg  <= 1'b0;
            l_rv_reg     <= 1'b0;
            l_rl_reg     <= 1'b0;
            l_add_reg    <= 1'b0;
            lhit_reg     <= 1'b0;
            lfree_reg    <= 1'b0;
            bid_have_reg <= 1'b0;
            ask_have_reg <= 1'b0;
            seq_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            xchk_reg     <= xchk_next;
            o_issue_reg  <= o_issue_next;
            o_rv_reg     <= o_rv_next;
            o_rl_reg     <= o_rl_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            l_issue_reg  <= l_issue_next;
            l_rv_reg     <= l_rv_next;
            l_rl_reg     <= l_rl_next;
            l_add_reg    <= l_add_next;
            lhit_reg     <= lhit_next;
            lfree_reg    <= lfree_next;
            bid_have_reg <= bid_have_next;
            ask_have_reg <= ask_have_next;
            seq_cnt_reg  <= seq_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

endmodule

### tb/obl3_book_checker.sv
`timescale 1ns / 100ps
// Book checker: mirrors the L3 book, predicts every result beat and compares it.
module obl3_book_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  obl3_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  obl3_pkg::out_item_t m_data,
    output int                  fail_count,
    output int                  pending_count
);
    import obl3_pkg::*;

    bit          ord_live [ORDER_SLOTS];
    logic [39:0] ord_ref  [ORDER_SLOTS];
    logic        ord_side [ORDER_SLOTS];
    logic [31:0] ord_px   [ORDER_SLOTS];
    logic [30:0] ord_qty  [ORDER_SLOTS];
    bit          lvl_live [NLVL];
    logic [31:0] lvl_px   [NLVL];
    logic [47:0] lvl_qty  [NLVL];
    bit          xref_live [SEEN_SLOTS];
    logic [39:0] xref_tab  [SEEN_SLOTS];
    int          xref_wr;
    logic [31:0] seq_ctr;
    out_item_t   book_updates [$];

    function automatic int find_ord(logic [39:0] r);
        for (int i = 0; i < ORDER_SLOTS; i++)
            if (ord_live[i] && ord_ref[i] == r) return i;
        return -1;
    endfunction

    function automatic int find_lvl(logic s, logic [31:0] p);
        for (int i = s * LEVELS_PER_SIDE; i < (s + 1) * LEVELS_PER_SIDE; i++)
            if (lvl_live[i] && lvl_px[i] == p) return i;
        return -1;
    endfunction

    function automatic void lvl_take(logic s, logic [31:0] p, logic [47:0] q);
        int l;
        l = find_lvl(s, p);
        if (l < 0) return;
        lvl_qty[l] = (q >= lvl_qty[l]) ? 48'd0 : lvl_qty[l] - q;
        if (lvl_qty[l] == 0) lvl_live[l] = 0;
    endfunction

    function automatic void drop_ord(int i);
        lvl_take(ord_side[i], ord_px[i], {17'd0, ord_qty[i]});
        ord_live[i] = 0;
    endfunction

    function automatic void rest_ord(logic s, logic [39:0] r, logic [31:0] p, logic [30:0] q);
        int i, f, l;
        logic [48:0] sum;
        f = -1;
        i = find_ord(r);
        if (i >= 0) drop_ord(i);
        for (i = 0; i < ORDER_SLOTS && f < 0; i++)
            if (!ord_live[i]) f = i;
        if (f < 0) return;
        l = find_lvl(s, p);
        if (l < 0) begin
            for (i = s * LEVELS_PER_SIDE; i < (s + 1) * LEVELS_PER_SIDE && l < 0; i++)
                if (!lvl_live[i]) l = i;
            if (l < 0) return;
            lvl_live[l] = 1;
            lvl_px[l]   = p;
            lvl_qty[l]  = '0;
        end
        sum = {1'b0, lvl_qty[l]} + {18'd0, q};
        lvl_qty[l] = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
        ord_live[f] = 1;
        ord_ref[f]  = r;
        ord_side[f] = s;
        ord_px[f]   = p;
        ord_qty[f]  = q;
    endfunction

    function automatic void best_level(logic s, output logic pres, output logic [31:0] p,
                                       output logic [47:0] q);
        int b;
        b = -1;
        for (int i = s * LEVELS_PER_SIDE; i < (s + 1) * LEVELS_PER_SIDE; i++) begin
            if (!lvl_live[i]) continue;
            if (b < 0) b = i;
            else if (s == 1'b0 ? lvl_px[i] > lvl_px[b] : lvl_px[i] < lvl_px[b]) b = i;
        end
        pres = (b >= 0);
        p    = (b >= 0) ? lvl_px[b] : '0;
        q    = (b >= 0) ? lvl_qty[b] : '0;
    endfunction

    function automatic out_item_t apply_event(in_item_t ev);
        out_item_t   r;
        logic        pos;
        logic [30:0] q;
        int          i;
        bit          seen;
        r   = '0;
        pos = (ev.volume > 0);
        q   = pos ? ev.volume[30:0] : '0;
        case (ev.cmd)
            CMD_ADD: begin
                if (pos && ev.limit_price != 0)
                    rest_ord(ev.buy_sell, ev.order_ref, ev.limit_price, q);
            end
            CMD_CANCEL: begin
                if (ev.order_ref == 0) begin
                    for (i = 0; i < ORDER_SLOTS; i++)
                        if (ord_live[i] && ord_side[i] == ev.buy_sell) ord_live[i] = 0;
                    for (i = ev.buy_sell * LEVELS_PER_SIDE;
                         i < (ev.buy_sell + 1) * LEVELS_PER_SIDE; i++)
                        lvl_live[i] = 0;
                end else begin
                    i = find_ord(ev.order_ref);
                    if (i >= 0) drop_ord(i);
                end
            end
            CMD_TRADE: begin
                if (pos) begin
                    i = find_ord(ev.order_ref);
                    if (i >= 0) begin
                        if (q >= ord_qty[i]) drop_ord(i);
                        else begin
                            ord_qty[i] = ord_qty[i] - q;
                            lvl_take(ord_side[i], ord_px[i], {17'd0, q});
                        end
                    end
                end
                if (ev.exec_ref != 0) begin
                    seen = 0;
                    for (i = 0; i < SEEN_SLOTS; i++)
                        if (xref_live[i] && xref_tab[i] == ev.exec_ref) seen = 1;
                    if (!seen) begin
                        xref_live[xref_wr] = 1;
                        xref_tab[xref_wr]  = ev.exec_ref;
                        xref_wr = (xref_wr + 1) % SEEN_SLOTS;
                        r.exec_valid   = 1;
                        r.exec_ref_out = ev.exec_ref;
                        r.exec_price   = ev.limit_price;
                        r.exec_volume  = q;
                        r.exec_time    = ev.event_time;
                        if (ev.sequence_no != 0) r.exec_sequence = ev.sequence_no;
                        else begin
                            r.exec_sequence = seq_ctr;
                            seq_ctr = seq_ctr + 32'd1;
                        end
                    end
                end
            end
            default: ;
        endcase
        best_level(1'b0, r.bid_present, r.best_bid_price, r.best_bid_volume);
        best_level(1'b1, r.ask_present, r.best_ask_price, r.best_ask_volume);
        return r;
    endfunction

    task automatic report(string fld, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", fld, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending_count = 0;
        xref_wr = 0;
        seq_ctr = '0;
        for (int i = 0; i < ORDER_SLOTS; i++) ord_live[i] = 0;
        for (int i = 0; i < NLVL; i++) lvl_live[i] = 0;
        for (int i = 0; i < SEEN_SLOTS; i++) xref_live[i] = 0;
    end

    always @(posedge aclk) begin
        out_item_t w;
        if (aresetn) begin
            if (s_valid && s_ready)
                book_updates.insert(book_updates.size(), apply_event(s_data));
            if (m_valid && m_ready) begin
                if (book_updates.size() == 0) begin
                    report("unexpected beat", 64'd1, 64'd0);
                end else begin
                    w = book_updates.pop_front();
                    if (m_data.exec_valid != w.exec_valid)
                        report("exec_valid", 64'(m_data.exec_valid), 64'(w.exec_valid));
                    if (m_data.exec_ref_out != w.exec_ref_out)
                        report("exec_ref_out", 64'(m_data.exec_ref_out), 64'(w.exec_ref_out));
                    if (m_data.exec_price != w.exec_price)
                        report("exec_price", 64'(m_data.exec_price), 64'(w.exec_price));
                    if (m_data.exec_volume != w.exec_volume)
                        report("exec_volume", 64'(m_data.exec_volume), 64'(w.exec_volume));
                    if (m_data.exec_time != w.exec_time)
                        report("exec_time", 64'(m_data.exec_time), 64'(w.exec_time));
                    if (m_data.exec_sequence != w.exec_sequence)
                        report("exec_sequence", 64'(m_data.exec_sequence),
                               64'(w.exec_sequence));
                    if (m_data.bid_present != w.bid_present)
                        report("bid_present", 64'(m_data.bid_present), 64'(w.bid_present));
                    if (m_data.best_bid_price != w.best_bid_price)
                        report("best_bid_price", 64'(m_data.best_bid_price),
                               64'(w.best_bid_price));
                    if (m_data.best_bid_volume != w.best_bid_volume)
                        report("best_bid_volume", 64'(m_data.best_bid_volume),
                               64'(w.best_bid_volume));
                    if (m_data.ask_present != w.ask_present)
                        report("ask_present", 64'(m_data.ask_present), 64'(w.ask_present));
                    if (m_data.best_ask_price != w.best_ask_price)
                        report("best_ask_price", 64'(m_data.best_ask_price),
                               64'(w.best_ask_price));
                    if (m_data.best_ask_volume != w.best_ask_volume)
                        report("best_ask_volume", 64'(m_data.best_ask_volume),
                               64'(w.best_ask_volume));
                end
            end
            pending_count = book_updates.size();
        end
    end
endmodule

### tb/tb_order_book_l3_update.sv
`timescale 1ns / 100ps
// Testbench top: drives events into the L3 book and gives the verdict.
module tb_order_book_l3_update;
    import obl3_pkg::*;

    // The watchdog limit sits well above the time of the longest event, the
    // clearing pass and the long receiver hold-off.
    localparam int STALL_LIMIT = 60000;
    localparam int HOLD_CYCLES = 12000;
    localparam int DRAIN_CYCLES = 3000;
    localparam int RANDOM_EVENTS = 1300;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;
    int        fail_count;
    int        pending_count;
    int        idle_cycles;
    bit        hold_req;
    logic [39:0] next_xref;
    logic [39:0] used_xrefs [$];

    order_book_l3_update u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    obl3_book_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Gap length: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Offer one beat, hold it until accepted, then idle for a random gap.
    task automatic send_event(in_item_t ev, bit gaps);
        int g;
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!s_ready);
        g = gaps ? pick_gap() : 0;
        @(negedge aclk);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g - 1) @(negedge aclk);
        end
    endtask

    function automatic in_item_t mk(cmd_t c, logic side, logic [39:0] oref, logic [31:0] px,
                                    logic signed [31:0] vol, logic [31:0] sq,
                                    logic [39:0] xr);
        in_item_t ev;
        ev.cmd         = c;
        ev.buy_sell    = side;
        ev.order_ref   = oref;
        ev.limit_price = px;
        ev.volume      = vol;
        ev.event_time  = 48'({$urandom(), $urandom()});
        ev.sequence_no = sq;
        ev.exec_ref    = xr;
        return ev;
    endfunction

    // Pick a trade execution reference: mostly fresh, some repeats, some absent.
    function automatic logic [39:0] pick_xref();
        int r;
        logic [39:0] x;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 35 && used_xrefs.size() > 0)
            return used_xrefs[$urandom_range(0, used_xrefs.size() - 1)];
        if (r < 45) x = 40'({$urandom(), $urandom()});
        else begin
            next_xref = next_xref + 40'd1;
            x = next_xref;
        end
        if (x == 0) x = 40'd1;
        used_xrefs.insert(used_xrefs.size(), x);
        return x;
    endfunction

    // Random event over a small reference pool and a narrow price band, so that
    // cancels and trades usually hit resting orders; full-width values mixed in.
    function automatic in_item_t rand_event();
        in_item_t ev;
        int r;
        logic side;
        r = $urandom_range(0, 99);
        side = 1'($urandom_range(0, 1));
        ev = mk(CMD_ADD, side, 40'($urandom_range(1, 48)),
                side ? $urandom_range(1004, 1014) : $urandom_range(996, 1006),
                $urandom_range(1, 500), ($urandom_range(0, 1) ? 32'd0 : $urandom()), '0);
        if (r < 45) ev.cmd = CMD_ADD;
        else if (r < 63) begin
            ev.cmd = CMD_CANCEL;
            if ($urandom_range(0, 19) == 0) ev.order_ref = '0;
        end else if (r < 95) begin
            ev.cmd = CMD_TRADE;
            ev.volume = $urandom_range(1, 600);
            ev.exec_ref = pick_xref();
        end else ev.cmd = CMD_OTHER;
        if ($urandom_range(0, 9) == 0) ev.volume = $urandom();
        if ($urandom_range(0, 14) == 0) ev.limit_price = $urandom();
        if ($urandom_range(0, 19) == 0) ev.order_ref = 40'({$urandom(), $urandom()});
        if ($urandom_range(0, 24) == 0 && ev.cmd != CMD_ADD) ev.limit_price = '0;
        return ev;
    endfunction

    // Receiver: random back-pressure, one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(0, 99) < 25) ? 1'b0 : 1'b1;
        end
    end

    // Watchdog: count cycles without any beat on either channel.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        hold_req  = 1'b0;
        next_xref = 40'h100;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extremes, rejects, duplicate add, record cases, side wipes.
        send_event(mk(CMD_ADD, 1'b0, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF,
                      '0, '0), 1);
        send_event(mk(CMD_ADD, 1'b1, 40'd1, 32'd1, 32'sd5, '0, '0), 1);
        send_event(mk(CMD_ADD, 1'b1, 40'd2, 32'd0, 32'sd5, '0, '0), 1);      // zero price
        send_event(mk(CMD_ADD, 1'b0, 40'd3, 32'd10, 32'sd0, '0, '0), 1);     // zero volume
        send_event(mk(CMD_ADD, 1'b0, 40'd3, 32'd10, -32'sd1, '0, '0), 1);    // negative
        send_event(mk(CMD_ADD, 1'b0, 40'd4, 32'd50, 32'sd7, '0, '0), 1);
        send_event(mk(CMD_ADD, 1'b0, 40'd5, 32'd50, 32'sd9, '0, '0), 1);
        send_event(mk(CMD_ADD, 1'b0, 40'd4, 32'd60, 32'sd3, '0, '0), 1);     // duplicate ref
        send_event(mk(CMD_TRADE, 1'b0, 40'd5, 32'd50, 32'sd4, '0, 40'h11), 1); // counter seq
        send_event(mk(CMD_TRADE, 1'b0, 40'd5, 32'd50, 32'sd4, '0, 40'h11), 1); // repeat xref
        send_event(mk(CMD_TRADE, 1'b0, 40'd5, 32'd50, 32'sd9, 32'hFFFF_FFFF,
                      40'hFF_FFFF_FFFF), 1);                                 // used up
        send_event(mk(CMD_TRADE, 1'b0, 40'd77, 32'd50, -32'sh8000_0000, '0, 40'h12), 1);
        send_event(mk(CMD_TRADE, 1'b1, 40'd1, 32'd1, 32'sd2, 32'd42, 40'd0), 1);
        send_event(mk(CMD_CANCEL, 1'b0, 40'd999, 32'd0, 32'sd0, '0, '0), 1);  // unknown
        send_event(mk(CMD_CANCEL, 1'b1, 40'd1, 32'd0, 32'sd0, '0, '0), 1);
        send_event(mk(CMD_OTHER, 1'b1, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, -32'sd1,
                      32'hFFFF_FFFF, 40'hFF_FFFF_FFFF), 1);
        send_event(mk(CMD_CANCEL, 1'b0, 40'd0, 32'd0, 32'sd0, '0, '0), 1);    // wipe bids
        send_event(mk(CMD_CANCEL, 1'b1, 40'd0, 32'd0, 32'sd0, '0, '0), 1);    // wipe asks

        // Fill the bid level table past its size, then wipe the side.
        for (int i = 0; i < LEVELS_PER_SIDE + 4; i++)
            send_event(mk(CMD_ADD, 1'b0, 40'd5000 + 40'(i), 32'd100 + 32'(i), 32'sd1,
                          '0, '0),
                       ($urandom_range(0, 3) == 0));
        send_event(mk(CMD_CANCEL, 1'b0, 40'd0, 32'd0, 32'sd0, '0, '0), 1);

        // Random events; one long receiver hold-off part way through.
        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            if (n == 200) hold_req = 1'b1;
            send_event(rand_event(), (n < 600 || n > 800));
        end
        s_valid <= 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
